/* design/smp_pkg.sv */
// ----------------------------------------------------------------------------
// smp_pkg
// Shared types and constants for the SHA-1 message padder.
// ----------------------------------------------------------------------------
`default_nettype none

package smp_pkg;

	// Default width of the message byte counter
	localparam int DEF_COUNT_BITS = 61;
	// Default depth of the job queue between front and back
	localparam int DEF_QUEUE_DEPTH = 4;

	localparam logic [7:0] PAD_BYTE    = 8'h80;
	localparam logic [3:0] LEN_HI_SLOT = 4'd14;
	localparam logic [3:0] LAST_SLOT   = 4'd15;
	localparam logic [2:0] TAIL_OCTET  = 3'b111;  // byte index 56..63 within a block

	// Kind of job handed from front to back
	typedef enum logic {
		JOB_DATA   = 1'b0,  // one complete message word
		JOB_FINISH = 1'b1   // first padding word, then fill and length
	} job_kind_t;

	// Byte lane of the next byte within its word
	typedef enum logic [1:0] {
		LANE_0 = 2'd0,
		LANE_1 = 2'd1,
		LANE_2 = 2'd2,
		LANE_3 = 2'd3
	} lane_t;

	typedef struct packed {
		job_kind_t   kind;
		logic [31:0] word;
		logic [3:0]  slot;
		logic        two_blk;  // length does not fit in the current block
	} job_t;

	// Back end state machine, one-hot
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_PAD  = 2'b10
	} back_state_t;

endpackage

`default_nettype wire

/* design/smp_front.sv */
// ----------------------------------------------------------------------------
// smp_front
// Accepts bytes and finish commands, packs bytes into words, counts the
// message length and queues data and finish jobs for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module smp_front import smp_pkg::*; #(
	parameter int COUNT_BITS = DEF_COUNT_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire logic                  cmd,
	input  wire logic [7:0]            data_byte,
	input  wire logic                  q_full,
	output logic                       q_push,
	output job_t                       q_job,
	output logic [COUNT_BITS+2:0]      q_len
);

	logic [23:0]           partial_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  accept;
	lane_t                 lane;
	logic [31:0]           pad_word;

	assign accept = push && !q_full;
	assign lane   = lane_t'(count_q[1:0]);

	// First padding word: buffered bytes, then 0x80, then zeros
	always_comb begin
		case (lane)
			LANE_0:  pad_word = {PAD_BYTE, 24'h0};
			LANE_1:  pad_word = {partial_q[7:0], PAD_BYTE, 16'h0};
			LANE_2:  pad_word = {partial_q[15:0], PAD_BYTE, 8'h0};
			LANE_3:  pad_word = {partial_q[23:0], PAD_BYTE};
			default: pad_word = {PAD_BYTE, 24'h0};
		endcase
	end

	// Job toward the queue
	always_comb begin
		q_push        = 1'b0;
		q_job.kind    = JOB_DATA;
		q_job.word    = {partial_q, data_byte};
		q_job.slot    = count_q[5:2];
		q_job.two_blk = 1'b0;
		if (accept) begin
			if (cmd) begin
				q_push        = 1'b1;
				q_job.kind    = JOB_FINISH;
				q_job.word    = pad_word;
				q_job.two_blk = (count_q[5:3] == TAIL_OCTET);
			end else if (lane == LANE_3) begin
				q_push = 1'b1;
			end
		end
	end

	// Message length in bits
	assign q_len = {count_q, 3'b000};

	// Packing and byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			count_q   <= '0;
		end else if (accept) begin
			if (cmd) begin
				partial_q <= '0;
				count_q   <= '0;
			end else begin
				partial_q <= (lane == LANE_3) ? 24'h0 : {partial_q[15:0], data_byte};
				count_q   <= count_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* design/smp_queue.sv */
// ----------------------------------------------------------------------------
// smp_queue
// Short first-in first-out job queue between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module smp_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  full,
	output logic                  empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [PW:0]      fill_q;

	assign full    = (fill_q == (PW+1)'(DEPTH));
	assign empty   = (fill_q == '0);
	assign rd_data = entry_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				fill_q <= fill_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* design/smp_back.sv */
// ----------------------------------------------------------------------------
// smp_back
// Takes jobs from the queue and emits words: one for a data job, the
// padding, fill and length words of one or two blocks for a finish job.
// Holds the output register seen by the result side.
// ----------------------------------------------------------------------------
`default_nettype none

module smp_back import smp_pkg::*; #(
	parameter int COUNT_BITS = DEF_COUNT_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  q_empty,
	input  wire job_t                  q_job,
	input  wire logic [COUNT_BITS+2:0] q_len,
	output logic                       q_pop,
	input  wire logic                  pop,
	output logic                       empty,
	output logic [31:0]                word,
	output logic [3:0]                 slot,
	output logic                       block_end,
	output logic                       last
);

	back_state_t           state_q, state_d;
	logic [3:0]            slot_q, slot_d;
	logic                  final_q, final_d;  // working in the block that holds the length
	logic [COUNT_BITS+2:0] len_q, len_d;
	logic [63:0]           len64;
	logic                  out_valid_q;
	logic                  can_load;
	logic                  gen;
	logic [31:0]           gen_word;
	logic [3:0]            gen_slot;
	logic                  gen_end;
	logic                  gen_last;

	assign can_load = !out_valid_q || pop;
	assign len64    = 64'(len_q);
	assign empty    = !out_valid_q;

	// Word sequencer
	always_comb begin
		state_d  = state_q;
		slot_d   = slot_q;
		final_d  = final_q;
		len_d    = len_q;
		q_pop    = 1'b0;
		gen      = 1'b0;
		gen_word = q_job.word;
		gen_slot = q_job.slot;
		gen_end  = (q_job.slot == LAST_SLOT);
		gen_last = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (!q_empty && can_load) begin
					gen   = 1'b1;
					q_pop = 1'b1;
					if (q_job.kind == JOB_FINISH) begin
						state_d = ST_PAD;
						slot_d  = q_job.slot + 1'b1;
						final_d = !q_job.two_blk || (q_job.slot == LAST_SLOT);
						len_d   = q_len;
					end
				end
			end
			ST_PAD: begin
				gen_slot = slot_q;
				gen_end  = (slot_q == LAST_SLOT);
				gen_last = final_q && (slot_q == LAST_SLOT);
				if (final_q && slot_q == LEN_HI_SLOT) begin
					gen_word = len64[63:32];
				end else if (final_q && slot_q == LAST_SLOT) begin
					gen_word = len64[31:0];
				end else begin
					gen_word = 32'h0;
				end
				if (can_load) begin
					gen    = 1'b1;
					slot_d = slot_q + 1'b1;
					if (slot_q == LAST_SLOT) begin
						final_d = 1'b1;
					end
					if (gen_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			slot_q  <= '0;
			final_q <= 1'b0;
		end else begin
			state_q <= state_d;
			slot_q  <= slot_d;
			final_q <= final_d;
		end
	end

	always_ff @(posedge clk) begin
		len_q <= len_d;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (gen) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (gen) begin
			word      <= gen_word;
			slot      <= gen_slot;
			block_end <= gen_end;
			last      <= gen_last;
		end
	end

endmodule

`default_nettype wire

/* design/sha1_message_padder.sv */
// ----------------------------------------------------------------------------
// sha1_message_padder
// SHA-1 message padding: byte packing, 0x80 and zero fill, bit length.
// ----------------------------------------------------------------------------
// Takes one message byte per cycle (cmd 0) and emits a word for every four
// bytes, with its slot in the 16-word block; block_end marks slot 15. A
// finish command (cmd 1) is also taken; the back end then puts out 3 to 18
// words, one per cycle while popped: buffered bytes with 0x80, zero words,
// and the 64-bit bit length in slots 14 and 15 of the final block, where
// last is set. Front and back are joined by a QUEUE_DEPTH-entry job queue,
// so the next message's bytes are taken while the padding is still being
// emitted; push is held off (full) only while that queue is full. A word
// waits in the output register until popped. The byte counter is
// COUNT_BITS wide and wraps.
`default_nettype none

module sha1_message_padder import smp_pkg::*; #(
	parameter int COUNT_BITS  = DEF_COUNT_BITS,
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic        cmd,
	input  wire logic [7:0]  data_byte,
	output logic             empty,
	input  wire logic        pop,
	output logic [31:0]      word,
	output logic [3:0]       slot,
	output logic             block_end,
	output logic             last
);

	localparam int LEN_W = COUNT_BITS + 3;
	localparam int QW    = $bits(job_t) + LEN_W;

	logic             q_push;
	logic             q_pop;
	logic             q_full;
	logic             q_empty;
	job_t             f_job;
	logic [LEN_W-1:0] f_len;
	job_t             b_job;
	logic [LEN_W-1:0] b_len;

	assign full = q_full;

	smp_front #(
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.cmd       (cmd),
		.data_byte (data_byte),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_job     (f_job),
		.q_len     (f_len)
	);

	smp_queue #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data ({f_job, f_len}),
		.rd_en   (q_pop),
		.rd_data ({b_job, b_len}),
		.full    (q_full),
		.empty   (q_empty)
	);

	smp_back #(
		.COUNT_BITS(COUNT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_job     (b_job),
		.q_len     (b_len),
		.q_pop     (q_pop),
		.pop       (pop),
		.empty     (empty),
		.word      (word),
		.slot      (slot),
		.block_end (block_end),
		.last      (last)
	);

`ifndef NO_ASSERTIONS
	// The final word always closes a block
	a_last_closes_block: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && last) |-> (block_end && slot == LAST_SLOT))
		else $error("last word not at end of block");

	// block_end only on slot 15
	a_block_end_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && block_end) |-> (slot == LAST_SLOT))
		else $error("block_end on wrong slot");

	// Front never queues a job into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("job queue overflow");

	// Queue only drained when a word is produced into a free output register
	a_pop_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (!q_empty && (empty || pop)))
		else $error("job taken without room for its word");
`endif

endmodule

`default_nettype wire
